// ----- rtl/nphs_pkg.sv -----
// Package for the nearest-point haversine search block.
// Holds the fixed-point constants and the CORDIC arctangent table; no dependencies.
`default_nettype none
package nphs_pkg;

   localparam int ID_BITS = 16;

   // register indexes on the csr port
   localparam logic [1:0] REG_ORIGIN_LAT = 2'd0;
   localparam logic [1:0] REG_ORIGIN_LON = 2'd1;
   localparam logic [1:0] REG_EXCLUDED   = 2'd2;

   // angles in degrees scaled by 2^22
   localparam logic signed [32:0] DEG360 = 33'sd1509949440;
   localparam logic signed [32:0] DEG180 = 33'sd754974720;
   localparam logic signed [32:0] DEG90  = 33'sd377487360;

   localparam logic [31:0] DEG2RAD_Q32 = 32'd74961321;
   localparam logic signed [35:0] CORDIC_K = 36'sd652032874;
   localparam logic [31:0] ONE_Q30 = 32'd1073741824;
   localparam logic [31:0] DIAM_KM = 32'd12742;
   localparam logic [30:0] DIST_CAP = 31'h7FFFFFFF;

   function automatic logic signed [35:0] atan_q30(input logic [4:0] idx);
      logic [31:0] v;
      case (idx)
         5'd0:  v = 32'h3243F6A8;
         5'd1:  v = 32'h1DAC6705;
         5'd2:  v = 32'h0FADBAFC;
         5'd3:  v = 32'h07F56EA6;
         5'd4:  v = 32'h03FEAB76;
         5'd5:  v = 32'h01FFD55B;
         5'd6:  v = 32'h00FFFAAA;
         5'd7:  v = 32'h007FFF55;
         5'd8:  v = 32'h003FFFEA;
         5'd9:  v = 32'h001FFFFD;
         5'd10: v = 32'h000FFFFF;
         5'd11: v = 32'h0007FFFF;
         5'd12: v = 32'h0003FFFF;
         5'd13: v = 32'h0001FFFF;
         5'd14: v = 32'h0000FFFF;
         5'd15: v = 32'h00007FFF;
         5'd16: v = 32'h00003FFF;
         5'd17: v = 32'h00001FFF;
         5'd18: v = 32'h00000FFF;
         5'd19: v = 32'h000007FF;
         5'd20: v = 32'h000003FF;
         5'd21: v = 32'h000001FF;
         5'd22: v = 32'h000000FF;
         5'd23: v = 32'h0000007F;
         5'd24: v = 32'h0000003F;
         5'd25: v = 32'h0000001F;
         5'd26: v = 32'h0000000F;
         5'd27: v = 32'h00000008;
         5'd28: v = 32'h00000004;
         5'd29: v = 32'h00000002;
         5'd30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return $signed({4'b0, v});
   endfunction

endpackage
`default_nettype wire

// ----- rtl/nearest_point_haversine_search.sv -----
// Top level of the nearest-point haversine search: stream ports, registers,
// running minimum and result register. Depends on nphs_pkg and nphs_core.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_tvalid/tready    | tdata id/lat/lon, tuser active flag, tlast last
//   rsp     | out | rsp_tvalid/tready    | tdata nearest id/distance, tuser found
//   csr     | in  | csr_we               | csr_index, csr_wdata
//
// A scored candidate holds the input while the core steps through the serial
// multiplier, the CORDIC unit and the square root in turn, one unit per step,
// then the distance is folded into the running minimum when the core is done.
// A skipped candidate bypasses the core. One item is in work at a time; req_tready
// falls while scoring and while a result waits in the rsp register.
// Reset is synchronous and clears the search state and registers.
`default_nettype none
module nearest_point_haversine_search
   import nphs_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,  // candidate_id, candidate_lat, candidate_lon, zeros
   input  wire logic        req_tuser,  // active flag
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,  // nearest_id, distance, zero
   output logic             rsp_tuser,  // found
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [30:0] csr_wdata
);

   logic signed [29:0] org_lat_ff;
   logic signed [30:0] org_lon_ff;
   logic [15:0] excl_ff;
   logic        busy_ff, last_ff, have_ff;
   logic [15:0] id_ff, best_id_ff;
   logic [30:0] best_ff;
   logic        rsp_valid_ff, rsp_found_ff;
   logic [47:0] rsp_data_ff;

   logic        accept, elig, core_done, better, fin, fin_last;
   logic [15:0] req_id;
   logic [30:0] core_dist;
   logic        nb_have;
   logic [15:0] nb_id;
   logic [30:0] nb_dist;

   assign req_tready = !busy_ff && !rsp_valid_ff;
   assign accept = req_tvalid && req_tready;
   assign req_id = req_tdata[15:0] & 16'((32'd1 << ID_BITS) - 32'd1);
   assign elig = req_tuser && (req_id != excl_ff);

   nphs_core u_core (
      .clock    (clock),
      .reset    (reset),
      .start    (accept && elig),
      .org_lat  (org_lat_ff),
      .org_lon  (org_lon_ff),
      .cand_lat (req_tdata[45:16]),
      .cand_lon (req_tdata[76:46]),
      .done     (core_done),
      .span_km  (core_dist)
   );

   always_comb begin
      better = core_done && (!have_ff || core_dist < best_ff);
      nb_have = have_ff || better;
      nb_id = better ? id_ff : best_id_ff;
      nb_dist = better ? core_dist : best_ff;
      fin = (accept && !elig) || core_done;
      fin_last = core_done ? last_ff : req_tlast;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         org_lat_ff <= '0;
         org_lon_ff <= '0;
         excl_ff <= '0;
         busy_ff <= 1'b0;
         have_ff <= 1'b0;
         best_ff <= DIST_CAP;
         best_id_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_ORIGIN_LAT: org_lat_ff <= csr_wdata[29:0];
               REG_ORIGIN_LON: org_lon_ff <= csr_wdata;
               REG_EXCLUDED:   excl_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (accept && elig) begin
            busy_ff <= 1'b1;
         end else if (core_done) begin
            busy_ff <= 1'b0;
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (fin) begin
            if (fin_last) begin
               // emit and start a fresh search
               rsp_valid_ff <= 1'b1;
               rsp_found_ff <= nb_have;
               rsp_data_ff <= nb_have ? {1'b0, nb_dist, nb_id} : 48'b0;
               have_ff <= 1'b0;
               best_ff <= DIST_CAP;
               best_id_ff <= '0;
            end else begin
               have_ff <= nb_have;
               best_ff <= nb_dist;
               best_id_ff <= nb_id;
            end
         end
      end
      if (accept) begin
         id_ff <= req_id;
         last_ff <= req_tlast;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_found_ff;

endmodule
`default_nettype wire

// ----- rtl/nphs_core.sv -----
// Distance engine: serial shift-add multiplier, iterative CORDIC and bit-serial
// square root, stepped by one sequencer. Depends on nphs_pkg.
`default_nettype none
module nphs_core
   import nphs_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [29:0] org_lat,
   input  wire logic signed [30:0] org_lon,
   input  wire logic signed [29:0] cand_lat,
   input  wire logic signed [30:0] cand_lon,
   output logic                    done,
   output logic [30:0]             span_km
);

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_DLAT_M = 5'd1;
   localparam logic [4:0] ST_DLAT_R = 5'd2;
   localparam logic [4:0] ST_DLON_M = 5'd3;
   localparam logic [4:0] ST_DLON_R = 5'd4;
   localparam logic [4:0] ST_LAT1_M = 5'd5;
   localparam logic [4:0] ST_LAT1_R = 5'd6;
   localparam logic [4:0] ST_LAT2_M = 5'd7;
   localparam logic [4:0] ST_LAT2_R = 5'd8;
   localparam logic [4:0] ST_SQ1    = 5'd9;
   localparam logic [4:0] ST_SQ2    = 5'd10;
   localparam logic [4:0] ST_C12    = 5'd11;
   localparam logic [4:0] ST_PQ     = 5'd12;
   localparam logic [4:0] ST_USQ    = 5'd13;
   localparam logic [4:0] ST_VSQ    = 5'd14;
   localparam logic [4:0] ST_VEC    = 5'd15;
   localparam logic [4:0] ST_DIST   = 5'd16;

   logic [4:0] step_ff, step_in;
   logic       run_ff, run_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       done_ff, done_in;
   logic [30:0] dist_ff, dist_in;

   logic [63:0] acc_ff, acc_in;
   logic [31:0] ma_ff, ma_in, mb_ff, mb_in;
   logic signed [35:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [61:0] n_ff, n_in, r_ff, r_in, bit_ff, bit_in;
   logic signed [35:0] ang_ff, ang_in;
   logic signed [35:0] s1_ff, s1_in, s2_ff, s2_in, c1_ff, c1_in, c2_ff, c2_in;
   logic signed [35:0] p_ff, p_in;
   logic [35:0] sq1_ff, sq1_in, sq2_ff, sq2_in;
   logic [30:0] a_ff, a_in, u_ff, u_in, v_ff, v_in;
   logic signed [29:0] lat2_ff, lat2_in;
   logic signed [30:0] lon2_ff, lon2_in;

   function automatic logic signed [32:0] wrap_deg(input logic signed [32:0] d);
      if (d >= DEG180) return d - DEG360;
      else if (d < -DEG180) return d + DEG360;
      else return d;
   endfunction

   function automatic logic signed [32:0] mirror_lat(input logic signed [32:0] l);
      if (l > DEG90) return DEG180 - l;
      else if (l < -DEG90) return -DEG180 - l;
      else return l;
   endfunction

   // floor of a signed product divided by 2^30, product given as magnitude and sign
   function automatic logic signed [35:0] fshr30(input logic [63:0] m, input logic neg);
      logic [63:0] t;
      logic signed [35:0] r;
      t = neg ? (m + 64'h3FFFFFFF) : m;
      r = $signed({2'b0, t[63:30]});
      return neg ? -r : r;
   endfunction

   logic signed [32:0] lat1_x, lat2_x, lon1_x, lon2_x;
   logic signed [32:0] dlat_w, dlon_w, l1_m, l2_m, deg_sel;
   logic               flip1, flip2, half, deg_neg;
   logic [31:0]        deg_mag, ma_sel, mb_sel;
   logic [63:0]        acc_step, rnd;
   logic signed [35:0] ang_val, dx, dy, at, q_val, xr_n, yr_n, zr_n, xv_n, yv_n, zv_n;
   logic signed [36:0] a_sum;
   logic [61:0]        sq_t, n_step, r_step;
   logic [63:0]        d_rnd;
   logic               last_cnt, is_mul, is_rot, mul_neg;

   always_comb begin
      lat1_x = {{3{org_lat[29]}}, org_lat};
      lat2_x = {{3{lat2_ff[29]}}, lat2_ff};
      lon1_x = {{2{org_lon[30]}}, org_lon};
      lon2_x = {{2{lon2_ff[30]}}, lon2_ff};
      dlat_w = wrap_deg(lat2_x - lat1_x);
      dlon_w = wrap_deg(lon2_x - lon1_x);
      l1_m = mirror_lat(lat1_x);
      l2_m = mirror_lat(lat2_x);
      flip1 = (lat1_x > DEG90) || (lat1_x < -DEG90);
      flip2 = (lat2_x > DEG90) || (lat2_x < -DEG90);

      case (step_ff)
         ST_DLAT_M: deg_sel = dlat_w;
         ST_DLON_M: deg_sel = dlon_w;
         ST_LAT1_M: deg_sel = l1_m;
         default:   deg_sel = l2_m;
      endcase
      half = (step_ff == ST_DLAT_M) || (step_ff == ST_DLON_M);
      deg_neg = deg_sel[32];
      deg_mag = deg_neg ? 32'(-deg_sel) : deg_sel[31:0];

      mul_neg = 1'b0;
      case (step_ff)
         ST_SQ1: begin
            ma_sel = s1_ff[35] ? 32'(-s1_ff) : s1_ff[31:0];
            mb_sel = ma_sel;
         end
         ST_SQ2: begin
            ma_sel = s2_ff[35] ? 32'(-s2_ff) : s2_ff[31:0];
            mb_sel = ma_sel;
         end
         ST_C12: begin
            ma_sel = c1_ff[35] ? 32'(-c1_ff) : c1_ff[31:0];
            mb_sel = c2_ff[35] ? 32'(-c2_ff) : c2_ff[31:0];
            mul_neg = c1_ff[35] ^ c2_ff[35];
         end
         ST_PQ: begin
            ma_sel = p_ff[35] ? 32'(-p_ff) : p_ff[31:0];
            mb_sel = sq2_ff[31:0];
            mul_neg = p_ff[35];
         end
         ST_DIST: begin
            ma_sel = ang_ff[31:0];
            mb_sel = DIAM_KM;
         end
         default: begin
            ma_sel = deg_mag;
            mb_sel = DEG2RAD_Q32;
         end
      endcase

      is_mul = (step_ff == ST_DLAT_M) || (step_ff == ST_DLON_M) || (step_ff == ST_LAT1_M) ||
               (step_ff == ST_LAT2_M) || (step_ff == ST_SQ1) || (step_ff == ST_SQ2) ||
               (step_ff == ST_C12) || (step_ff == ST_PQ) || (step_ff == ST_DIST);
      is_rot = (step_ff == ST_DLAT_R) || (step_ff == ST_DLON_R) ||
               (step_ff == ST_LAT1_R) || (step_ff == ST_LAT2_R);

      // one multiplier bit per cycle, most significant first
      acc_step = {acc_ff[62:0], 1'b0} + (mb_ff[31] ? {32'b0, ma_ff} : 64'b0);
      rnd = half ? ((acc_step + 64'h0100_0000) >> 25) : ((acc_step + 64'h0080_0000) >> 24);
      ang_val = deg_neg ? -$signed(rnd[35:0]) : $signed(rnd[35:0]);
      q_val = fshr30(acc_step, mul_neg);
      a_sum = $signed({1'b0, sq1_ff}) + {q_val[35], q_val};
      d_rnd = (acc_step + 64'h2000) >> 14;

      dx = y_ff >>> cnt_ff;
      dy = x_ff >>> cnt_ff;
      at = atan_q30(cnt_ff);
      xr_n = (z_ff >= 0) ? x_ff - dx : x_ff + dx;
      yr_n = (z_ff >= 0) ? y_ff + dy : y_ff - dy;
      zr_n = (z_ff >= 0) ? z_ff - at : z_ff + at;
      xv_n = (y_ff >= 0) ? x_ff + dx : x_ff - dx;
      yv_n = (y_ff >= 0) ? y_ff - dy : y_ff + dy;
      zv_n = (y_ff >= 0) ? z_ff + at : z_ff - at;

      sq_t = r_ff + bit_ff;
      n_step = (n_ff >= sq_t) ? n_ff - sq_t : n_ff;
      r_step = (n_ff >= sq_t) ? (r_ff >> 1) + bit_ff : r_ff >> 1;

      last_cnt = ((step_ff == ST_USQ) || (step_ff == ST_VSQ)) ? (cnt_ff == 5'd30)
                                                              : (cnt_ff == 5'd31);
   end

   always_comb begin
      step_in = step_ff;
      run_in = run_ff;
      cnt_in = cnt_ff;
      done_in = 1'b0;
      dist_in = dist_ff;
      acc_in = acc_ff;
      ma_in = ma_ff;
      mb_in = mb_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      n_in = n_ff;
      r_in = r_ff;
      bit_in = bit_ff;
      ang_in = ang_ff;
      s1_in = s1_ff;
      s2_in = s2_ff;
      c1_in = c1_ff;
      c2_in = c2_ff;
      p_in = p_ff;
      sq1_in = sq1_ff;
      sq2_in = sq2_ff;
      a_in = a_ff;
      u_in = u_ff;
      v_in = v_ff;
      lat2_in = lat2_ff;
      lon2_in = lon2_ff;

      if (step_ff == ST_IDLE) begin
         if (start) begin
            lat2_in = cand_lat;
            lon2_in = cand_lon;
            step_in = ST_DLAT_M;
            run_in = 1'b0;
         end
      end else if (!run_ff) begin
         // load the unit for this step
         run_in = 1'b1;
         cnt_in = 5'd0;
         acc_in = 64'b0;
         ma_in = ma_sel;
         mb_in = mb_sel;
         if (is_rot) begin
            x_in = CORDIC_K;
            y_in = 36'sd0;
            z_in = ang_ff;
         end else begin
            x_in = $signed({5'b0, v_ff});
            y_in = $signed({5'b0, u_ff});
            z_in = 36'sd0;
         end
         n_in = (step_ff == ST_USQ) ? {1'b0, a_ff, 30'b0}
                                    : {1'b0, 31'(ONE_Q30) - a_ff, 30'b0};
         r_in = 62'b0;
         bit_in = 62'h1000_0000_0000_0000;
      end else begin
         cnt_in = cnt_ff + 5'd1;
         acc_in = acc_step;
         mb_in = {mb_ff[30:0], 1'b0};
         if (is_rot) begin
            x_in = xr_n;
            y_in = yr_n;
            z_in = zr_n;
         end else begin
            x_in = xv_n;
            y_in = yv_n;
            z_in = zv_n;
         end
         n_in = n_step;
         r_in = r_step;
         bit_in = bit_ff >> 2;
         if (last_cnt) begin
            run_in = 1'b0;
            step_in = step_ff + 5'd1;
            case (step_ff)
               ST_DLAT_M, ST_DLON_M, ST_LAT1_M, ST_LAT2_M: ang_in = ang_val;
               ST_DLAT_R: s1_in = yr_n;
               ST_DLON_R: s2_in = yr_n;
               ST_LAT1_R: c1_in = flip1 ? -xr_n : xr_n;
               ST_LAT2_R: c2_in = flip2 ? -xr_n : xr_n;
               ST_SQ1:    sq1_in = {2'b0, acc_step[63:30]};
               ST_SQ2:    sq2_in = {2'b0, acc_step[63:30]};
               ST_C12:    p_in = q_val;
               ST_PQ: begin
                  if (a_sum < 0) a_in = 31'd0;
                  else if (a_sum > $signed({5'b0, ONE_Q30})) a_in = 31'(ONE_Q30);
                  else a_in = a_sum[30:0];
               end
               ST_USQ:    u_in = r_step[30:0];
               ST_VSQ:    v_in = r_step[30:0];
               ST_VEC:    ang_in = (zv_n < 0) ? 36'sd0 : zv_n;
               ST_DIST: begin
                  dist_in = (d_rnd[63:31] != 33'b0) ? DIST_CAP : d_rnd[30:0];
                  done_in = 1'b1;
                  step_in = ST_IDLE;
               end
               default: step_in = ST_IDLE;
            endcase
         end
      end
      if (is_mul == 1'b0 && is_rot == 1'b0 && step_ff != ST_IDLE && step_ff != ST_USQ &&
          step_ff != ST_VSQ && step_ff != ST_VEC) begin
         step_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
         run_ff <= 1'b0;
         cnt_ff <= 5'd0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         run_ff <= run_in;
         cnt_ff <= cnt_in;
         done_ff <= done_in;
      end
      dist_ff <= dist_in;
      acc_ff <= acc_in;
      ma_ff <= ma_in;
      mb_ff <= mb_in;
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      n_ff <= n_in;
      r_ff <= r_in;
      bit_ff <= bit_in;
      ang_ff <= ang_in;
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      c1_ff <= c1_in;
      c2_ff <= c2_in;
      p_ff <= p_in;
      sq1_ff <= sq1_in;
      sq2_ff <= sq2_in;
      a_ff <= a_in;
      u_ff <= u_in;
      v_ff <= v_in;
      lat2_ff <= lat2_in;
      lon2_ff <= lon2_in;
   end

   assign done = done_ff;
   assign span_km = dist_ff;

endmodule
`default_nettype wire

// ----- test/nearest_point_haversine_search_test.sv -----
// Testbench for nearest_point_haversine_search: directed table then random searches,
// scored by a fixed-point haversine predictor. Depends on nphs_pkg and the RTL top level.
`timescale 1ns / 100ps
module nearest_point_haversine_search_test
   import nphs_pkg::*;
();

   localparam logic [1:0] REG_UNUSED     = 2'd3;
   localparam int SETTLE_CYCLES = 800;
   localparam int HOLD_CYCLES = 8000;
   localparam longint LAT_MAX = 377487360;
   localparam longint LON_MAX = 754974720;

   typedef struct packed {
      logic [15:0] id;
      logic [29:0] lat;
      logic [30:0] lon;
      logic        active;
      logic        last;
   } candidate_t;

   typedef struct packed {
      logic [15:0] id;
      logic [30:0] span;
      logic        found;
   } nearest_t;

   typedef struct packed {
      candidate_t cand;
      logic       typed;
      nearest_t   want;
   } script_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [79:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [30:0] csr_wdata = '0;

   nearest_point_haversine_search i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor state
   logic signed [29:0] home_lat = '0;
   logic signed [30:0] home_lon = '0;
   logic [15:0] excluded_id = '0;
   logic [30:0] best_dist = DIST_CAP;
   logic [15:0] best_id = '0;
   logic have_best = 1'b0;
   nearest_t pending_nearest[$];
   int errors = 0;

   int burst_left = 0;
   bit stall_on = 1'b0;
   bit hold_go = 1'b0;

   function automatic longint atan_step(int i);
      return longint'(atan_q30(5'(i)));
   endfunction

   function automatic void cordic_rotate(input longint angle, output longint c,
                                         output longint s);
      longint x, y, z, dx, dy;
      x = 652032874; y = 0; z = angle;
      for (int i = 0; i < 32; i++) begin
         dx = y >>> i; dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= atan_step(i);
         end else begin
            x += dx; y -= dy; z += atan_step(i);
         end
      end
      c = x; s = y;
   endfunction

   function automatic longint cordic_angle(longint x, longint y);
      longint z, dx, dy;
      z = 0;
      for (int i = 0; i < 32; i++) begin
         dx = y >>> i; dy = x >>> i;
         if (y >= 0) begin
            x += dx; y -= dy; z += atan_step(i);
         end else begin
            x -= dx; y += dy; z -= atan_step(i);
         end
      end
      return (z < 0) ? 0 : z;
   endfunction

   function automatic longint root_floor(logic [63:0] n);
      logic [63:0] r, b;
      r = 0; b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n -= r + b; r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return longint'(r);
   endfunction

   // reduce into [-180, 180) degrees
   function automatic longint fold_deg(longint d);
      longint r;
      r = ((d % 1509949440) + 1509949440) % 1509949440;
      if (r >= 754974720) r -= 1509949440;
      return r;
   endfunction

   function automatic longint deg_to_angle(longint d, int sh);
      longint m, r;
      m = (d < 0) ? -d : d;
      r = (m * 74961321 + (longint'(1) << (sh - 1))) >> sh;
      return (d < 0) ? -r : r;
   endfunction

   function automatic longint sine_of_half(longint delta);
      longint c, s;
      cordic_rotate(deg_to_angle(fold_deg(delta), 25), c, s);
      return s;
   endfunction

   function automatic longint cosine_of_lat(longint lat);
      longint l, c, s;
      bit flip;
      l = fold_deg(lat); flip = 0;
      if (l > LAT_MAX) begin
         l = 754974720 - l; flip = 1;
      end else if (l < -LAT_MAX) begin
         l = -754974720 - l; flip = 1;
      end
      cordic_rotate(deg_to_angle(l, 24), c, s);
      return flip ? -c : c;
   endfunction

   function automatic logic [30:0] great_circle_km(longint lat1, longint lon1,
                                                  longint lat2, longint lon2);
      longint s1, s2, c1, c2, a, u, v, z, d;
      s1 = sine_of_half(lat2 - lat1);
      s2 = sine_of_half(lon2 - lon1);
      c1 = cosine_of_lat(lat1);
      c2 = cosine_of_lat(lat2);
      a = ((s1 * s1) >> 30) + ((((c1 * c2) >>> 30) * ((s2 * s2) >> 30)) >>> 30);
      if (a < 0) a = 0;
      if (a > 1073741824) a = 1073741824;
      u = root_floor(64'(a) << 30);
      v = root_floor(64'(1073741824 - a) << 30);
      z = cordic_angle(v, u);
      d = (12742 * z + 8192) >> 14;
      return (d > 64'h7FFFFFFF) ? DIST_CAP : 31'(d);
   endfunction

   // update the running minimum; returns 1 with the result on a last item
   function automatic bit track_nearest(candidate_t c, output nearest_t r);
      logic [30:0] d;
      if (c.active && c.id != excluded_id) begin
         d = great_circle_km(home_lat, home_lon, $signed(c.lat), $signed(c.lon));
         if (!have_best || d < best_dist) begin
            best_dist = d; best_id = c.id; have_best = 1'b1;
         end
      end
      r = '{id: have_best ? best_id : 16'd0, span: have_best ? best_dist : 31'd0,
            found: have_best};
      if (!c.last) return 0;
      best_dist = DIST_CAP; best_id = '0; have_best = 1'b0;
      return 1;
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [30:0] value);
      @(negedge clock);
      csr_we = 1'b1; csr_index = idx; csr_wdata = value;
      @(posedge clock);
      case (idx)
         REG_ORIGIN_LAT: home_lat = value[29:0];
         REG_ORIGIN_LON: home_lon = value[30:0];
         REG_EXCLUDED:   excluded_id = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // offer one transaction; valid stays high inside a burst
   task automatic send_candidate(candidate_t c, bit typed, nearest_t want);
      nearest_t r;
      @(negedge clock);
      if (burst_left == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 4))
            @(negedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_tvalid = 1'b1;
      req_tdata = {3'b0, c.lon, c.lat, c.id};
      req_tuser = c.active;
      req_tlast = c.last;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      if (track_nearest(c, r)) pending_nearest = {pending_nearest, (typed ? want : r)};
   endtask

   task automatic drain_and_settle();
      @(negedge clock);
      req_tvalid = 1'b0;
      burst_left = 0;
      while (pending_nearest.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [29:0] pick_lat();
      case ($urandom_range(0, 9))
         0, 1: return 30'($urandom);
         2:    return 30'(longint'($urandom_range(0, 4000)) - 2000);
         default: return 30'(longint'($urandom_range(0, 2 * LAT_MAX)) - LAT_MAX);
      endcase
   endfunction

   function automatic logic [30:0] pick_lon();
      case ($urandom_range(0, 9))
         0, 1: return 31'($urandom);
         2:    return 31'(longint'($urandom_range(0, 4000)) - 2000);
         default: return 31'(longint'($urandom_range(0, 2 * LON_MAX)) - LON_MAX);
      endcase
   endfunction

   // receiver: own stall pattern, plus one long hold-off
   always @(negedge clock) begin : sink_pacing
      static int hold_left = 0;
      static bit held = 1'b0;
      if (hold_go && !held) begin
         hold_left = HOLD_CYCLES; held = 1'b1;
      end
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= stall_on ? ($urandom_range(0, 2) != 0) : 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_nearest.size() == 0) begin
            $error("unexpected result: nearest_id %0d distance %0d found %0b",
                   rsp_tdata[15:0], rsp_tdata[46:16], rsp_tuser);
            errors++;
         end else begin
            nearest_t w;
            w = pending_nearest.pop_front();
            if (rsp_tdata[15:0] !== w.id) begin
               $error("nearest_id: expected %0d, got %0d", w.id, rsp_tdata[15:0]);
               errors++;
            end
            if (rsp_tdata[46:16] !== w.span) begin
               $error("distance: expected %0d, got %0d", w.span, rsp_tdata[46:16]);
               errors++;
            end
            if (rsp_tuser !== w.found) begin
               $error("found: expected %0b, got %0b", w.found, rsp_tuser);
               errors++;
            end
         end
      end
   end

   initial begin
      #40ms;
      $display("tb: failure");
      $finish;
   end

   initial begin
      script_row_t script[] = '{
         // excluded id (0 at reset) and inactive item both end empty searches
         '{'{16'h0000, 30'd0, 31'd0, 1'b1, 1'b1}, 1'b1, '{16'd0, 31'd0, 1'b0}},
         '{'{16'h0005, 30'd0, 31'd0, 1'b0, 1'b1}, 1'b1, '{16'd0, 31'd0, 1'b0}},
         '{'{16'h0001, 30'(LAT_MAX), 31'd0, 1'b1, 1'b0}, 1'b0, '0},
         '{'{16'h0002, 30'(-LAT_MAX), 31'(LON_MAX), 1'b1, 1'b0}, 1'b0, '0},
         '{'{16'h0003, 30'd0, 31'(-LON_MAX), 1'b1, 1'b0}, 1'b0, '0},
         '{'{16'hFFFF, 30'd0, 31'd0, 1'b1, 1'b1}, 1'b0, '0},
         // tie: the earlier one stays
         '{'{16'h0007, 30'd1000, 31'd1000, 1'b1, 1'b0}, 1'b0, '0},
         '{'{16'h0008, 30'd1000, 31'd1000, 1'b1, 1'b1}, 1'b0, '0},
         // out-of-range coordinates
         '{'{16'h0009, 30'h1FFFFFFF, 31'h3FFFFFFF, 1'b1, 1'b0}, 1'b0, '0},
         '{'{16'h000A, 30'h20000000, 31'h40000000, 1'b1, 1'b1}, 1'b0, '0},
         '{'{16'h000B, 30'(LAT_MAX), 31'(LON_MAX), 1'b0, 1'b0}, 1'b0, '0},
         '{'{16'h000C, 30'(LAT_MAX), 31'(-LON_MAX), 1'b1, 1'b1}, 1'b0, '0},
         '{'{16'hAAAA, 30'h3FFFFFFF, 31'h7FFFFFFF, 1'b1, 1'b0}, 1'b0, '0},
         '{'{16'h5555, 30'd1, 31'd1, 1'b0, 1'b1}, 1'b0, '0}
      };
      candidate_t c, prev;
      int left;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[k]) send_candidate(script[k].cand, script[k].typed, script[k].want);
      drain_and_settle();

      prev = '0;
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(REG_ORIGIN_LAT, 31'(LAT_MAX));
               write_reg(REG_ORIGIN_LON, 31'(LON_MAX));
               write_reg(REG_UNUSED, 31'h7FFFFFFF);
            end
            1: begin
               write_reg(REG_ORIGIN_LAT, 31'(30'(-LAT_MAX)));
               write_reg(REG_ORIGIN_LON, 31'(-LON_MAX));
            end
            2: begin
               write_reg(REG_ORIGIN_LAT, 31'h1FFFFFFF);
               write_reg(REG_ORIGIN_LON, 31'h40000000);
            end
            default: begin
               write_reg(REG_ORIGIN_LAT, 31'(pick_lat()));
               write_reg(REG_ORIGIN_LON, pick_lon());
            end
         endcase
         write_reg(REG_EXCLUDED, (phase == 1) ? 31'hFFFF : 31'($urandom_range(0, 15)));
         stall_on = phase[0];
         for (int n = 0; n < 150; n++) begin
            if (phase == 2 && n == 20) hold_go = 1'b1;
            if (n % 6 == 0) left = $urandom_range(1, 8);
            c.id = ($urandom_range(0, 9) == 0) ? excluded_id
                 : ($urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 15)));
            c.lat = pick_lat();
            c.lon = pick_lon();
            if ($urandom_range(0, 9) == 0) begin
               c.lat = prev.lat; c.lon = prev.lon;
            end
            c.active = ($urandom_range(0, 6) != 0);
            left--;
            c.last = (left <= 0) || (n == 149);
            if (c.last) left = $urandom_range(1, 8);
            send_candidate(c, 1'b0, '0);
            prev = c;
         end
         drain_and_settle();
      end

      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/nphs_pkg.sv
rtl/nphs_core.sv
rtl/nearest_point_haversine_search.sv
test/nearest_point_haversine_search_test.sv
